// ===== design/psw_pkg.sv =====
package psw_pkg;

  localparam int BURST_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int JOB_IDX_W   = 4;
  localparam int TIME_W      = 20;
  localparam int MAX_JOBS_DEF = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One stored job: priority, burst and arrival position.
  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
    logic [JOB_IDX_W-1:0] idx;
  } job_entry_t;

  localparam int ENTRY_W = $bits(job_entry_t);

  // Control from the sequencer to the result stage.
  typedef struct packed {
    logic strobe;
    logic last;
    logic clear;
  } emit_ctl_t;

endpackage

// ===== design/psw_ram.sv =====
module psw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/psw_emit.sv =====
module psw_emit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  psw_pkg::emit_ctl_t                   ctl,
  input  psw_pkg::job_entry_t                  entry,
  input  logic                                 ovf,
  output logic                                 out_valid,
  output logic [psw_pkg::JOB_IDX_W-1:0]        out_job_index,
  output logic [psw_pkg::BURST_W-1:0]          out_job_burst,
  output logic [psw_pkg::TIME_W-1:0]           out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]           out_turnaround_time,
  output logic                                 out_batch_overflow,
  output logic                                 out_last_result
);

  localparam int SUM_W = psw_pkg::TIME_W + 1;

  logic                           valid_r;
  logic [psw_pkg::TIME_W-1:0]     run_wait_r;
  logic [psw_pkg::TIME_W-1:0]     run_wait_nxt;
  logic [psw_pkg::JOB_IDX_W-1:0]  idx_r;
  logic [psw_pkg::BURST_W-1:0]    burst_r;
  logic [psw_pkg::TIME_W-1:0]     wait_r;
  logic [psw_pkg::TIME_W-1:0]     tat_r;
  logic                           ovf_r;
  logic                           last_r;
  logic [SUM_W-1:0]               sum;
  logic [psw_pkg::TIME_W-1:0]     tat;

  always_comb begin
    sum = SUM_W'(run_wait_r) + SUM_W'(entry.burst);
    // saturate at the top of the time range
    tat = (sum > SUM_W'(psw_pkg::TIME_MAX)) ? psw_pkg::TIME_MAX
                                            : sum[psw_pkg::TIME_W-1:0];
    run_wait_nxt = run_wait_r;
    if (ctl.clear) begin
      run_wait_nxt = '0;
    end else if (ctl.strobe) begin
      run_wait_nxt = tat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      run_wait_r <= '0;
    end else begin
      valid_r    <= ctl.strobe;
      run_wait_r <= run_wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.strobe) begin
      idx_r   <= entry.idx;
      burst_r <= entry.burst;
      wait_r  <= run_wait_r;
      tat_r   <= tat;
      ovf_r   <= ovf;
      last_r  <= ctl.last;
    end
  end

  assign out_valid           = valid_r;
  assign out_job_index       = idx_r;
  assign out_job_burst       = burst_r;
  assign out_wait_time       = wait_r;
  assign out_turnaround_time = tat_r;
  assign out_batch_overflow  = ovf_r;
  assign out_last_result     = last_r;

endmodule

// ===== design/priority_schedule_wait_times_unit.sv =====
// Non-preemptive priority scheduler.
// Input channel: a job transaction (in_burst_time, in_job_priority, in_is_last)
// is taken at a rising edge with start high and busy low. Jobs are loaded
// into a job RAM; a job arriving when MAX_JOBS are held is dropped and marks
// the batch as overflowed. The job with in_is_last closes the batch and
// raises busy.
// Scheduling: a selection sort on priority walks the RAM through its single
// read port. Pass i reads n-i entries, one per cycle, and then writes the
// swap through the single write port, in state SWAP_A and then SWAP_B.
// Result channel: one result per job in execution order, one per cycle,
// marked by out_valid for exactly one cycle; out_last_result flags the final
// one. The first result passes the RAM read register and the result register
// after the last swap (after the closing job for a single-job batch), and busy
// falls in the cycle after the final result. The receiver cannot stall.
// Reset (rst_n low, synchronous) empties the batch; the RAM contents are not
// cleared, as only entries written in the current batch are ever read.
module priority_schedule_wait_times_unit #(
  parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [psw_pkg::BURST_W-1:0]      in_burst_time,
  input  logic [psw_pkg::PRIO_W-1:0]       in_job_priority,
  input  logic                             in_is_last,
  output logic                             out_valid,
  output logic [psw_pkg::JOB_IDX_W-1:0]    out_job_index,
  output logic [psw_pkg::BURST_W-1:0]      out_job_burst,
  output logic [psw_pkg::TIME_W-1:0]       out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]       out_turnaround_time,
  output logic                             out_batch_overflow,
  output logic                             out_last_result
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int EXT_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_JOBS);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_SWAP_A = 3'd2;
  localparam logic [2:0] ST_SWAP_B = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  logic [CNT_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]          rd_tag_r, rd_tag_nxt;
  psw_pkg::job_entry_t       min_r, min_nxt;
  logic [IDX_W-1:0]          min_pos_r, min_pos_nxt;
  psw_pkg::job_entry_t       head_r, head_nxt;

  logic                      accept;
  logic [CNT_W-1:0]          batch_n;
  logic [CNT_W-1:0]          last_tag;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  psw_pkg::job_entry_t       ram_wdata;
  logic [psw_pkg::ENTRY_W-1:0] ram_rdata;
  psw_pkg::job_entry_t       rd_entry;
  psw_pkg::emit_ctl_t        emit_ctl;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign rd_entry = psw_pkg::job_entry_t'(ram_rdata);
  assign last_tag = count_r - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    pos_nxt     = pos_r;
    rd_ptr_nxt  = rd_ptr_r;
    rd_vld_nxt  = 1'b0;
    rd_tag_nxt  = rd_tag_r;
    min_nxt     = min_r;
    min_pos_nxt = min_pos_r;
    head_nxt    = head_r;
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = min_r;
    batch_n     = count_r;
    emit_ctl    = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // store the job, or drop it once the RAM is full
          if (count_r < CAP) begin
            ram_we          = 1'b1;
            ram_waddr       = count_r[IDX_W-1:0];
            ram_wdata.prio  = in_job_priority;
            ram_wdata.burst = in_burst_time;
            ram_wdata.idx   = psw_pkg::JOB_IDX_W'(count_r);
            count_nxt       = count_r + CNT_W'(1);
            batch_n         = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            pos_nxt    = '0;
            rd_ptr_nxt = '0;
            state_nxt  = (batch_n >= CNT_W'(2)) ? ST_SCAN : ST_EMIT;
          end
        end
      end

      ST_SCAN: begin
        // issue reads from the current head to the end of the batch
        if (rd_ptr_r < count_r) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_tag_nxt = rd_ptr_r[IDX_W-1:0];
        end else if (!rd_vld_r) begin
          state_nxt = ST_SWAP_A;
        end
        // track the minimum; strict less-than keeps the earliest on ties
        if (rd_vld_r) begin
          if (rd_tag_r == pos_r) begin
            head_nxt    = rd_entry;
            min_nxt     = rd_entry;
            min_pos_nxt = pos_r;
          end else if (rd_entry.prio < min_r.prio) begin
            min_nxt     = rd_entry;
            min_pos_nxt = rd_tag_r;
          end
        end
      end

      ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = min_r;
        state_nxt = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = min_pos_r;
        ram_wdata = head_r;
        // advance to the next pass while at least two entries remain
        if (EXT_W'(pos_r) + EXT_W'(2) < EXT_W'(count_r)) begin
          pos_nxt    = pos_r + IDX_W'(1);
          rd_ptr_nxt = CNT_W'(pos_r) + CNT_W'(1);
          state_nxt  = ST_SCAN;
        end else begin
          rd_ptr_nxt = '0;
          state_nxt  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (rd_ptr_r < count_r) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_tag_nxt = rd_ptr_r[IDX_W-1:0];
        end else if (!rd_vld_r) begin
          // batch done: drop the count and flag, clear the running wait
          emit_ctl.clear = 1'b1;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
        emit_ctl.strobe = rd_vld_r;
        emit_ctl.last   = (rd_tag_r == last_tag[IDX_W-1:0]);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_vld_r <= 1'b0;
      rd_ptr_r <= '0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      rd_vld_r <= rd_vld_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // datapath registers: no reset needed
  always_ff @(posedge clk) begin
    rd_tag_r  <= rd_tag_nxt;
    min_r     <= min_nxt;
    min_pos_r <= min_pos_nxt;
    head_r    <= head_nxt;
  end

  psw_ram #(
    .WIDTH (psw_pkg::ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  psw_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (emit_ctl),
    .entry               (rd_entry),
    .ovf                 (ovf_r),
    .out_valid           (out_valid),
    .out_job_index       (out_job_index),
    .out_job_burst       (out_job_burst),
    .out_wait_time       (out_wait_time),
    .out_turnaround_time (out_turnaround_time),
    .out_batch_overflow  (out_batch_overflow),
    .out_last_result     (out_last_result)
  );

`ifndef SYNTH
  // results only follow reads issued while emitting
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("result strobe outside the emit phase");

  // the job count never passes the RAM depth
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("job count beyond capacity");

  // the swap target lies within the loaded batch
  a_swap_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP_B) |-> (CNT_W'(min_pos_r) < count_r))
    else $error("swap address outside the batch");

  // nothing follows the final result of a batch
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |=> !out_valid)
    else $error("result after the final one of the batch");
`endif

endmodule
